// File: rtl/core/pvmc_pkg.sv
`default_nettype none
package pvmc_pkg;

  // operation codes
  localparam logic [2:0] OP_CPU_RD = 3'd0;
  localparam logic [2:0] OP_CPU_WR = 3'd1;
  localparam logic [2:0] OP_PAL_RD = 3'd2;
  localparam logic [2:0] OP_PAL_WR = 3'd3;
  localparam logic [2:0] OP_GLYPH  = 3'd4;
  localparam logic [2:0] OP_PIXEL  = 3'd5;

  // configuration register indexes
  localparam logic [2:0] REG_DISPLAY = 3'd0;
  localparam logic [2:0] REG_PLANES  = 3'd1;
  localparam logic [2:0] REG_CMODE   = 3'd2;
  localparam logic [2:0] REG_CPOS    = 3'd3;

  localparam int WORK_BYTES  = 16384;
  localparam int WORK_AW     = 14;
  localparam int GLYPH_AW    = 11;
  localparam int ATTR_OFFSET = 'h800;
  localparam int X_NARROW    = 320;
  localparam int X_WIDE      = 640;
  localparam int COLS_NARROW = 40;
  localparam int COLS_WIDE   = 80;
  localparam int DEF_PLANE_BYTES = 16384;
  localparam int DEF_LINE_COUNT  = 200;

  localparam int IN_W  = 56;
  localparam int OUT_W = 16;

  typedef struct packed {
    logic [7:0]  display;
    logic [4:0]  planes;
    logic [6:0]  cmode;
    logic [13:0] cpos;
  } cfg_t;

  // decoded operation handed from front to back
  typedef struct packed {
    logic [2:0]  op;
    logic [13:0] addr;
    logic [7:0]  data;
    logic        in_range;
    logic [13:0] off;
    logic [13:0] txt_off;
    logic [2:0]  xl;
    logic [2:0]  yl;
    logic        fr4;
    logic        fr5;
  } cmd_t;

endpackage
`default_nettype wire

// File: rtl/core/planar_video_memory_and_pixel_composer.sv
// planar video memory and pixel composer
// in_ channel: one word per operation (cpu read/write, palette read/write,
//   glyph load, pixel render); out_ channel: exactly one result word per
//   operation, in order (read byte and pen, zero where unused)
// cfg_ port: plain register write, index 0..3; the user writes it only
//   while idle, which the block itself does not enforce
// a front stage decodes the word and precomputes bitmap and text offsets,
//   a two-entry queue decouples it from the back stage that owns memories
// sequencing: a pixel passes idle, P1, P2 and P3, set by the single read
//   port of plane 3 (tile, then attribute) followed by the glyph fetch;
//   writes finish in idle, cpu reads pass idle and CRD, one op at a time
// reset: a clearing pass over every work ram address zeroes the video
//   planes and fills work ram with 0xFF; in_tready stays low until it ends
// receiver stall: result held in the output register, queue fills, then
//   in_tready drops; nothing is lost
`default_nettype none
module planar_video_memory_and_pixel_composer #(
  parameter int PLANE_BYTES = pvmc_pkg::DEF_PLANE_BYTES,
  parameter int LINE_COUNT  = pvmc_pkg::DEF_LINE_COUNT
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // opcode[2:0] address[16:3] data[24:17] pixel_x[34:25] pixel_y[42:35]
  // frame_count[50:43], zero fill above
  input  wire logic [pvmc_pkg::IN_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // read_data[7:0] pixel_pen[15:8]
  output logic [pvmc_pkg::OUT_W-1:0]         out_tdata,
  input  wire logic                          cfg_wr_en,
  input  wire logic [2:0]                    cfg_index,
  input  wire logic [13:0]                   cfg_wr_data
);
  pvmc_pkg::cfg_t cfg_r;
  pvmc_pkg::cmd_t front_cmd, head;
  logic full, empty, pop, clear_done, push;
  logic [7:0] out_rd, out_pen;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.display <= 8'd0;
      cfg_r.planes  <= 5'd8;
      cfg_r.cmode   <= 7'd0;
      cfg_r.cpos    <= 14'd0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        pvmc_pkg::REG_DISPLAY: cfg_r.display <= cfg_wr_data[7:0];
        pvmc_pkg::REG_PLANES:  cfg_r.planes  <= cfg_wr_data[4:0];
        pvmc_pkg::REG_CMODE:   cfg_r.cmode   <= cfg_wr_data[6:0];
        pvmc_pkg::REG_CPOS:    cfg_r.cpos    <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // no words taken during the clearing pass
  assign in_tready = !full && clear_done;
  assign push      = in_tvalid && in_tready;

  pvmc_front #(.LINE_COUNT(LINE_COUNT)) u_front (
    .word (in_tdata),
    .cfg  (cfg_r),
    .cmd  (front_cmd)
  );

  pvmc_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (front_cmd),
    .full  (full),
    .pop   (pop),
    .dout  (head),
    .empty (empty)
  );

  pvmc_back #(.PLANE_BYTES(PLANE_BYTES)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head       (head),
    .empty      (empty),
    .pop        (pop),
    .clear_done (clear_done),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_rd     (out_rd),
    .out_pen    (out_pen)
  );

  assign out_tdata = {out_pen, out_rd};
endmodule
`default_nettype wire

// File: rtl/core/pvmc_front.sv
`default_nettype none
module pvmc_front #(
  parameter int LINE_COUNT = pvmc_pkg::DEF_LINE_COUNT
) (
  input  wire logic [pvmc_pkg::IN_W-1:0] word,
  input  wire pvmc_pkg::cfg_t            cfg,
  output pvmc_pkg::cmd_t                 cmd
);
  logic [9:0]  px;
  logic [7:0]  py;
  logic        wide;
  logic [6:0]  cols;
  logic [9:0]  xmax;
  logic [14:0] line_off;
  logic [11:0] row_off;
  logic [13:0] txt_raw;

  always_comb begin
    px       = word[34:25];
    py       = word[42:35];
    wide     = cfg.display[6];
    cols     = wide ? 7'(pvmc_pkg::COLS_WIDE) : 7'(pvmc_pkg::COLS_NARROW);
    xmax     = wide ? 10'(pvmc_pkg::X_WIDE) : 10'(pvmc_pkg::X_NARROW);
    line_off = py * cols;
    row_off  = py[7:3] * cols;
    txt_raw  = 14'(row_off) + 14'(px[9:3]);

    cmd.op       = word[2:0];
    cmd.addr     = word[16:3];
    cmd.data     = word[24:17];
    cmd.in_range = (px < xmax) && (py < 8'(LINE_COUNT));
    cmd.off      = 14'(line_off) + 14'(px[9:3]);
    cmd.txt_off  = wide ? txt_raw : {txt_raw[12:0], 1'b0};
    cmd.xl       = px[2:0];
    cmd.yl       = py[2:0];
    cmd.fr4      = word[47];
    cmd.fr5      = word[48];
  end
endmodule
`default_nettype wire

// File: rtl/core/pvmc_fifo.sv
`default_nettype none
module pvmc_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire pvmc_pkg::cmd_t din,
  output logic                full,
  input  wire logic           pop,
  output pvmc_pkg::cmd_t      dout,
  output logic                empty
);
  pvmc_pkg::cmd_t slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full  = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);
  assign dout  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push && !full) slot_r[wr_ptr_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push && !full) wr_ptr_r <= ~wr_ptr_r;
      if (pop && !empty) rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/pvmc_back.sv
`default_nettype none
module pvmc_back #(
  parameter int PLANE_BYTES = pvmc_pkg::DEF_PLANE_BYTES
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire pvmc_pkg::cfg_t cfg,
  input  wire pvmc_pkg::cmd_t head,
  input  wire logic           empty,
  output logic                pop,
  output logic                clear_done,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [7:0]          out_rd,
  output logic [7:0]          out_pen
);
  localparam int PA = $clog2(PLANE_BYTES);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_CRD   = 6'b000100,
    ST_P1    = 6'b001000,
    ST_P2    = 6'b010000,
    ST_P3    = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [pvmc_pkg::WORK_AW-1:0] clr_r, clr_nxt;

  logic [7:0] plane_mem [4][PLANE_BYTES];
  logic [7:0] work_mem [pvmc_pkg::WORK_BYTES];
  logic [7:0] glyph_mem [2**pvmc_pkg::GLYPH_AW];

  logic [3:0]    plane_we, plane_re;
  logic [PA-1:0] plane_wa;
  logic [7:0]    plane_wd;
  logic [PA-1:0] plane_ra [4];
  logic [7:0]    plane_q [4];
  logic          work_we, work_re;
  logic [pvmc_pkg::WORK_AW-1:0] work_wa;
  logic [7:0]    work_wd, work_q;
  logic          glyph_we, glyph_re;
  logic [7:0]    glyph_q;

  pvmc_pkg::cmd_t cur_r;
  logic           cur_ld, tile_ld, pal_we;
  logic [7:0]     tile_r;
  logic [7:0]     pal_r [8];
  logic [7:0]     pal_new [8];
  logic           mono_r, mono_new;

  logic       out_valid_r, out_load, out_free;
  logic [7:0] out_rd_r, out_pen_r, ld_rd, ld_pen;
  logic [7:0] rd_calc, pen_calc;
  logic [13:0] attr_sum;

  logic b, r, g, tbit, on;
  logic [2:0] color, tcolor;
  logic [3:0] row_sum;

  assign out_free   = !out_valid_r || out_ready;
  assign out_valid  = out_valid_r;
  assign out_rd     = out_rd_r;
  assign out_pen    = out_pen_r;
  assign clear_done = (state_r != ST_CLEAR);
  assign attr_sum   = cur_r.txt_off + 14'(pvmc_pkg::ATTR_OFFSET);

  // palette update and mono detect
  always_comb begin
    mono_new = 1'b1;
    for (int i = 0; i < 8; i++) begin
      pal_new[i] = (3'(i) == head.addr[2:0]) ? head.data : pal_r[i];
      if (pal_new[i] != 8'd0) mono_new = 1'b0;
    end
  end

  // cpu read merge
  always_comb begin
    rd_calc = 8'hFF;
    if (!cfg.planes[4]) begin
      rd_calc = work_q;
    end else begin
      for (int p = 0; p < 4; p++)
        if (!cfg.planes[p]) rd_calc = rd_calc & plane_q[p];
    end
  end

  // pixel composition from bitmap, text cell and cursor
  always_comb begin
    b = plane_q[0][~cur_r.xl];
    r = plane_q[1][~cur_r.xl];
    g = plane_q[2][~cur_r.xl];
    if (mono_r) begin
      color = ((b & cfg.display[0]) | (r & cfg.display[1]) | (g & cfg.display[2]))
              ? 3'd7 : 3'd0;
    end else begin
      color = {g, r, b};
    end
    pen_calc = pal_r[color];
    tcolor   = cfg.display[7] ? 3'd7 : plane_q[3][2:0];
    tbit     = glyph_q[~cur_r.xl] ^ plane_q[3][5];
    if (tbit && (tcolor != 3'd0)) pen_calc = {5'd0, tcolor};
    case (cfg.cmode[6:5])
      2'd0:    on = 1'b1;
      2'd1:    on = 1'b0;
      2'd2:    on = cur_r.fr4;
      default: on = cur_r.fr5;
    endcase
    row_sum = {1'b0, cur_r.yl} + {1'b0, cfg.cmode[2:0]};
    if ((cur_r.txt_off == cfg.cpos) && on && (row_sum < 4'd8)) pen_calc = 8'd7;
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    pop       = 1'b0;
    cur_ld    = 1'b0;
    tile_ld   = 1'b0;
    pal_we    = 1'b0;
    out_load  = 1'b0;
    ld_rd     = 8'd0;
    ld_pen    = 8'd0;
    plane_we  = 4'd0;
    plane_re  = 4'd0;
    plane_wa  = head.addr[PA-1:0];
    plane_wd  = head.data;
    for (int p = 0; p < 4; p++) plane_ra[p] = head.addr[PA-1:0];
    work_we   = 1'b0;
    work_re   = 1'b0;
    work_wa   = head.addr;
    work_wd   = head.data;
    glyph_we  = 1'b0;
    glyph_re  = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        plane_we = 4'hF;
        plane_wa = clr_r[PA-1:0];
        plane_wd = 8'd0;
        work_we  = 1'b1;
        work_wa  = clr_r;
        work_wd  = 8'hFF;
        clr_nxt  = clr_r + 1'b1;
        if (&clr_r) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (!empty && out_free) begin
          pop    = 1'b1;
          cur_ld = 1'b1;
          case (head.op)
            pvmc_pkg::OP_CPU_RD: begin
              plane_re  = 4'hF;
              work_re   = 1'b1;
              state_nxt = ST_CRD;
            end
            pvmc_pkg::OP_CPU_WR: begin
              if (cfg.planes[4]) plane_we = ~cfg.planes[3:0];
              else work_we = 1'b1;
              out_load = 1'b1;
            end
            pvmc_pkg::OP_PAL_RD: begin
              out_load = 1'b1;
              ld_rd    = pal_r[head.addr[2:0]];
            end
            pvmc_pkg::OP_PAL_WR: begin
              pal_we   = 1'b1;
              out_load = 1'b1;
            end
            pvmc_pkg::OP_GLYPH: begin
              glyph_we = 1'b1;
              out_load = 1'b1;
            end
            pvmc_pkg::OP_PIXEL: begin
              if (head.in_range) begin
                plane_re = 4'hF;
                for (int p = 0; p < 3; p++) plane_ra[p] = head.off[PA-1:0];
                plane_ra[3] = head.txt_off[PA-1:0];
                state_nxt   = ST_P1;
              end else begin
                out_load = 1'b1;
              end
            end
            default: out_load = 1'b1;
          endcase
        end
      end
      ST_CRD: begin
        if (out_free) begin
          out_load  = 1'b1;
          ld_rd     = rd_calc;
          state_nxt = ST_IDLE;
        end
      end
      ST_P1: begin
        // tile code is in, fetch the attribute byte
        tile_ld     = 1'b1;
        plane_re[3] = 1'b1;
        plane_ra[3] = attr_sum[PA-1:0];
        state_nxt   = ST_P2;
      end
      ST_P2: begin
        glyph_re  = 1'b1;
        state_nxt = ST_P3;
      end
      ST_P3: begin
        if (out_free) begin
          out_load  = 1'b1;
          ld_pen    = pen_calc;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    for (int p = 0; p < 4; p++) begin
      if (plane_we[p]) plane_mem[p][plane_wa] <= plane_wd;
      if (plane_re[p]) plane_q[p] <= plane_mem[p][plane_ra[p]];
    end
  end

  always_ff @(posedge clk) begin
    if (work_we) work_mem[work_wa] <= work_wd;
    if (work_re) work_q <= work_mem[head.addr];
  end

  always_ff @(posedge clk) begin
    if (glyph_we) glyph_mem[head.addr[pvmc_pkg::GLYPH_AW-1:0]] <= head.data;
    if (glyph_re) glyph_q <= glyph_mem[{tile_r, cur_r.yl}];
  end

  always_ff @(posedge clk) begin
    if (cur_ld) cur_r <= head;
    if (tile_ld) tile_r <= plane_q[3];
    if (out_load) begin
      out_rd_r  <= ld_rd;
      out_pen_r <= ld_pen;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      mono_r      <= 1'b0;
      for (int i = 0; i < 8; i++) pal_r[i] <= 8'd0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_load || (out_valid_r && !out_ready);
      if (pal_we) begin
        for (int i = 0; i < 8; i++) pal_r[i] <= pal_new[i];
        mono_r <= mono_new;
      end
    end
  end

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("back state not one-hot");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (state_r == ST_IDLE)) else $error("pop outside idle");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !out_load) else $error("result overwritten");
  a_plane_wr: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r != ST_CLEAR) && (plane_we != 4'd0)) |-> cfg.planes[4])
    else $error("plane write without video select");
endmodule
`default_nettype wire

// File: tb/testbench.sv
module testbench;

  localparam int PB = pvmc_pkg::DEF_PLANE_BYTES;
  localparam int LC = pvmc_pkg::DEF_LINE_COUNT;
  localparam int IW = pvmc_pkg::IN_W;
  localparam int OW = pvmc_pkg::OUT_W;
  localparam int LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  // opcode, address, data, pixel_x, pixel_y, frame_count from bit 0 up
  logic [IW-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  // read_data, pixel_pen from bit 0 up
  logic [OW-1:0] out_tdata;
  logic cfg_wr_en = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [13:0] cfg_wr_data = '0;
  logic in_acc = 1'b0;

  planar_video_memory_and_pixel_composer DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data)
  );

  always #6 clk = ~clk;

  typedef struct packed {
    logic [7:0] frame;
    logic [7:0] py;
    logic [9:0] px;
    logic [7:0] data;
    logic [13:0] addr;
    logic [2:0] op;
  } op_word_t;

  // shadow copy of the block state
  logic [7:0] vid_mem [0:4*PB-1];
  logic [7:0] work_mem [0:pvmc_pkg::WORK_BYTES-1];
  logic [7:0] glyph_mem [0:2047];
  logic [7:0] pal [0:7];
  logic mono;
  logic [7:0] r_disp;
  logic [4:0] r_planes;
  logic [6:0] r_cmode;
  logic [13:0] r_cpos;

  op_word_t pending_words[$];
  logic [15:0] expected_results[$];
  int unsigned in_idle_pct = 0, out_stall_pct = 0;
  int errors = 0;
  int cycles = 0;

  function automatic logic [7:0] vbyte(int p, int o);
    return vid_mem[p * PB + (o & (PB - 1))];
  endfunction

  // pen of one rendered pixel in the current state
  function automatic logic [7:0] pixel_pen(int x, int y, logic [7:0] fr);
    bit wide;
    int w, cols, off, sh, clr, txt_off, tile, attr, tc, bt, on;
    logic [7:0] pen, pb0, pb1, pb2;
    wide = r_disp[6];
    w = wide ? pvmc_pkg::X_WIDE : pvmc_pkg::X_NARROW;
    cols = wide ? pvmc_pkg::COLS_WIDE : pvmc_pkg::COLS_NARROW;
    if (x >= w || y >= LC) return 8'd0;
    off = y * (w / 8) + (x >> 3);
    sh = 7 - (x & 7);
    pb0 = vbyte(0, off);
    pb1 = vbyte(1, off);
    pb2 = vbyte(2, off);
    clr = int'({pb2[sh], pb1[sh], pb0[sh]});
    if (mono) clr = ((clr & int'(r_disp[2:0])) != 0) ? 7 : 0;
    pen = pal[clr];
    // text cell overlay
    txt_off = (y >> 3) * cols + (x >> 3);
    if (!wide) txt_off = txt_off << 1;
    tile = int'(vbyte(3, txt_off));
    attr = int'(vbyte(3, txt_off + pvmc_pkg::ATTR_OFFSET));
    tc = r_disp[7] ? 7 : (attr & 7);
    bt = int'(glyph_mem[(tile * 8 + (y & 7)) & 2047][sh]);
    if (attr[5]) bt ^= 1;
    if (bt != 0 && tc != 0) pen = 8'(tc);
    // cursor overlay
    if (txt_off == int'(r_cpos)) begin
      case (r_cmode[6:5])
        2'd0: on = 1;
        2'd1: on = 0;
        2'd2: on = int'(fr[4]);
        default: on = int'(fr[5]);
      endcase
      if (on != 0 && (y & 7) < 8 - int'(r_cmode[2:0])) pen = 8'd7;
    end
    return pen;
  endfunction

  // applies one word to the shadow state and returns {pen, read byte}
  function automatic logic [15:0] apply_word(op_word_t w);
    logic [7:0] rd, pen;
    rd = 8'd0;
    pen = 8'd0;
    case (w.op)
      pvmc_pkg::OP_CPU_RD: begin
        if (!r_planes[4]) rd = work_mem[w.addr];
        else begin
          rd = 8'hFF;
          for (int p = 0; p < 4; p++) if (!r_planes[p]) rd &= vbyte(p, int'(w.addr));
        end
      end
      pvmc_pkg::OP_CPU_WR: begin
        if (!r_planes[4]) work_mem[w.addr] = w.data;
        else
          for (int p = 0; p < 4; p++)
            if (!r_planes[p]) vid_mem[p * PB + (int'(w.addr) & (PB - 1))] = w.data;
      end
      pvmc_pkg::OP_PAL_RD: rd = pal[w.addr[2:0]];
      pvmc_pkg::OP_PAL_WR: begin
        pal[w.addr[2:0]] = w.data;
        mono = 1'b1;
        for (int i = 0; i < 8; i++) if (pal[i] != 0) mono = 1'b0;
      end
      pvmc_pkg::OP_GLYPH: glyph_mem[w.addr[10:0]] = w.data;
      pvmc_pkg::OP_PIXEL: pen = pixel_pen(int'(w.px), int'(w.py), w.frame);
      default: ;
    endcase
    return {pen, rd};
  endfunction

  // driver: next queued word goes out at the falling edge
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_acc)) begin
      if (pending_words.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
        in_tdata <= IW'(pending_words.pop_front());
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    out_tready <= ($urandom_range(99) >= out_stall_pct);
  end

  // prediction happens at acceptance so it follows the block's own order
  always @(posedge clk) begin
    in_acc <= in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready)
      expected_results.push_back(apply_word(op_word_t'(in_tdata[$bits(op_word_t)-1:0])));
  end

  // monitor
  always @(posedge clk) begin
    logic [15:0] exp_word;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word %h", out_tdata);
      end else begin
        exp_word = expected_results.pop_front();
        if (out_tdata[7:0] !== exp_word[7:0] || out_tdata[15:8] !== exp_word[15:8]) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: read exp %h got %h, pen exp %h got %h",
                     exp_word[7:0], out_tdata[7:0], exp_word[15:8], out_tdata[15:8]);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  function automatic op_word_t mk(logic [2:0] op, logic [13:0] a, logic [7:0] d,
                                  logic [9:0] x = 10'd0, logic [7:0] y = 8'd0,
                                  logic [7:0] f = 8'd0);
    op_word_t w;
    w.op = op; w.addr = a; w.data = d; w.px = x; w.py = y; w.frame = f;
    return w;
  endfunction

  // tile codes in the text area stay below 32, so pixels only fetch loaded glyph rows
  task automatic queue_word(op_word_t w);
    op_word_t q;
    q = w;
    if (q.op == pvmc_pkg::OP_CPU_WR && r_planes[4] && !r_planes[3] &&
        ((int'(q.addr) & (PB - 1)) < pvmc_pkg::ATTR_OFFSET))
      q.data = q.data & 8'h1F;
    pending_words.push_back(q);
  endtask

  // random pixel, now and then outside the active area
  function automatic op_word_t rand_pixel();
    return mk(pvmc_pkg::OP_PIXEL, 14'($urandom), 8'($urandom),
      ($urandom_range(9) == 0) ? 10'($urandom)
                               : 10'($urandom_range(r_disp[6] ? 639 : 319)),
      ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(LC - 1)),
      8'($urandom));
  endfunction

  // waits until every queued word has been answered, then settles
  task automatic drain();
    while (pending_words.size() > 0 || in_tvalid || expected_results.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [13:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1; cfg_index <= idx; cfg_wr_data <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      pvmc_pkg::REG_DISPLAY: r_disp = val[7:0];
      pvmc_pkg::REG_PLANES: r_planes = val[4:0];
      pvmc_pkg::REG_CMODE: r_cmode = val[6:0];
      pvmc_pkg::REG_CPOS: r_cpos = val;
      default: ;
    endcase
  endtask

  initial begin
    op_word_t w;
    int sel;
    for (int i = 0; i < 4 * PB; i++) vid_mem[i] = 8'd0;
    for (int i = 0; i < pvmc_pkg::WORK_BYTES; i++) work_mem[i] = 8'hFF;
    for (int i = 0; i < 2048; i++) glyph_mem[i] = 8'd0;
    for (int i = 0; i < 8; i++) pal[i] = 8'd0;
    mono = 1'b0; r_disp = 8'd0; r_planes = 5'd8; r_cmode = 7'd0; r_cpos = 14'd0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // load the glyph rows of tile codes 0 to 31
    for (int i = 0; i < 256; i++)
      queue_word(mk(pvmc_pkg::OP_GLYPH, 14'(i), 8'($urandom)));
    drain();

    // directed: extremes, each opcode but glyph load, mask cases
    write_reg(pvmc_pkg::REG_PLANES, 14'h10);
    queue_word(mk(pvmc_pkg::OP_CPU_WR, 14'h3FFF, 8'hA5));
    queue_word(mk(pvmc_pkg::OP_CPU_RD, 14'h3FFF, 8'd0));
    queue_word(mk(pvmc_pkg::OP_PAL_RD, 14'h3FFF, 8'd0));
    queue_word(mk(pvmc_pkg::OP_PAL_WR, 14'h3FF9, 8'hFF));
    queue_word(mk(pvmc_pkg::OP_PAL_RD, 14'd1, 8'd0));
    queue_word(mk(pvmc_pkg::OP_PAL_WR, 14'd1, 8'h00));
    queue_word(mk(pvmc_pkg::OP_PIXEL, 14'd0, 8'd0, 10'd0, 8'd0, 8'hFF));
    queue_word(mk(pvmc_pkg::OP_PIXEL, 14'd0, 8'd0, 10'd319, 8'd199, 8'd0));
    queue_word(mk(pvmc_pkg::OP_PIXEL, 14'd0, 8'd0, 10'd320, 8'd0, 8'd0));
    queue_word(mk(pvmc_pkg::OP_PIXEL, 14'd0, 8'd0, 10'h3FF, 8'hFF, 8'd0));
    queue_word(mk(3'd6, 14'h3FFF, 8'hFF, 10'h3FF, 8'hFF, 8'hFF));
    queue_word(mk(3'd7, 14'd0, 8'h5A, 10'd0, 8'd0, 8'd0));
    drain();
    write_reg(pvmc_pkg::REG_PLANES, 14'h1F);
    queue_word(mk(pvmc_pkg::OP_CPU_WR, 14'd5, 8'h33));
    queue_word(mk(pvmc_pkg::OP_CPU_RD, 14'd5, 8'd0));
    drain();
    write_reg(pvmc_pkg::REG_PLANES, 14'h00);
    write_reg(pvmc_pkg::REG_DISPLAY, 14'hFF);
    write_reg(pvmc_pkg::REG_CMODE, 14'h7F);
    write_reg(pvmc_pkg::REG_CPOS, 14'h3FFF);
    write_reg(3'd7, 14'h3FFF);
    queue_word(mk(pvmc_pkg::OP_CPU_WR, 14'd0, 8'hFF));
    queue_word(mk(pvmc_pkg::OP_CPU_RD, 14'd0, 8'd0));
    queue_word(mk(pvmc_pkg::OP_PIXEL, 14'd0, 8'd0, 10'd639, 8'd199, 8'hFF));
    queue_word(mk(pvmc_pkg::OP_PIXEL, 14'd0, 8'd0, 10'd640, 8'd0, 8'd0));
    drain();

    // random phases: no idling, sender idle, receiver stall, both
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin in_idle_pct = 0; out_stall_pct = 0; end
        1: begin in_idle_pct = 63; out_stall_pct = 0; end
        2: begin in_idle_pct = 0; out_stall_pct = 63; end
        default: begin in_idle_pct = 14; out_stall_pct = 14; end
      endcase
      write_reg(pvmc_pkg::REG_DISPLAY, (ph == 1) ? 14'h00 : (ph == 5) ? 14'hFF
                                       : 14'($urandom_range(255)));
      write_reg(pvmc_pkg::REG_PLANES, (ph == 2) ? 14'h00 : (ph == 6) ? 14'h1F
                                      : 14'($urandom_range(31) | 16));
      write_reg(pvmc_pkg::REG_CMODE, (ph < 4) ? 14'(ph << 5) : 14'($urandom_range(127)));
      write_reg(pvmc_pkg::REG_CPOS, ($urandom_range(1) != 0) ? 14'($urandom_range(300) << 1)
                                    : 14'($urandom));
      for (int i = 0; i < 80; i++) begin
        sel = $urandom_range(99);
        if (sel < 40) w = rand_pixel();
        else if (sel < 60)
          w = mk(pvmc_pkg::OP_CPU_WR, ($urandom_range(1) != 0) ? 14'($urandom_range(1100))
                 : 14'($urandom_range(1100) + pvmc_pkg::ATTR_OFFSET), 8'($urandom));
        else if (sel < 72) w = mk(pvmc_pkg::OP_CPU_RD, 14'($urandom), 8'd0);
        else if (sel < 82)
          w = mk(pvmc_pkg::OP_PAL_WR, 14'($urandom),
                 ($urandom_range(2) == 0) ? 8'd0 : 8'($urandom));
        else if (sel < 90) w = mk(pvmc_pkg::OP_PAL_RD, 14'($urandom), 8'($urandom));
        else if (sel < 96) w = mk(pvmc_pkg::OP_GLYPH, 14'($urandom), 8'($urandom));
        else w = mk(3'($urandom_range(7)), 14'($urandom), 8'($urandom), 10'($urandom),
                    8'($urandom), 8'($urandom));
        if (w.op == pvmc_pkg::OP_PIXEL) w = rand_pixel();
        queue_word(w);
      end
      drain();
    end

    if (errors == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

endmodule
